>>> sv/thb_pkg.sv
// Shared types, constants and header field values for the frame header builder.
package thb_pkg;

    // Header geometry and limits.
    localparam int HDR_BYTES   = 54;
    localparam int MAX_PAYLOAD = 1460;
    localparam int IP_TCP_HDR  = 40;
    localparam int QUEUE_DEPTH = 2;

    // Fixed header field values.
    localparam logic [47:0] MAC_RESET       = 48'h5349474D414F;
    localparam logic [7:0]  BCAST_BYTE      = 8'hFF;
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL      = 8'h45;
    localparam logic [7:0]  IP_TOS          = 8'h00;
    localparam logic [15:0] IP_FLAGS_DF     = 16'h4000;
    localparam logic [7:0]  IP_TTL          = 8'd64;
    localparam logic [7:0]  IP_PROTOCOL     = 8'd6;
    localparam logic [7:0]  TCP_DATA_OFFSET = 8'h50;

    // Sum of the constant IPv4 header words that enter the checksum.
    localparam logic [17:0] IP_CONST_SUM =
        18'({IP_VER_IHL, IP_TOS}) + 18'(IP_FLAGS_DF) + 18'({IP_TTL, IP_PROTOCOL});

    // One classified segment, as held in the queue between front and back.
    typedef struct packed {
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [7:0]  tcp_flags;
        logic [15:0] window_size;
        logic [10:0] payload_len;
        logic [15:0] hdr_csum;
    } thb_item_t;

endpackage

>>> sv/thb_front.sv
// Front end: takes a descriptor, clamps the payload length and builds the IPv4 checksum.
module thb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        source_ip,
    input  logic [31:0]        dest_ip,
    input  logic [15:0]        source_port,
    input  logic [15:0]        dest_port,
    input  logic [31:0]        seq_num,
    input  logic [31:0]        ack_num,
    input  logic [7:0]         tcp_flags,
    input  logic [15:0]        window_size,
    input  logic [10:0]        payload_len,
    output logic               push_valid,
    output thb_pkg::thb_item_t push_item,
    input  logic               queue_full
);
    import thb_pkg::*;

    logic        hold_valid_reg;
    thb_item_t   item_reg;
    logic [17:0] addr_sum_reg;
    logic [17:0] misc_sum_reg;

    logic        accept;
    logic [10:0] plen_sat;
    logic [15:0] ip_len;
    logic [18:0] full_sum;
    logic [16:0] fold_one;
    logic [15:0] fold_two;

    // The held item leaves as soon as the queue has room, so a new one can enter.
    assign push_valid = hold_valid_reg && !queue_full;
    assign busy       = hold_valid_reg && queue_full;
    assign accept     = start && !busy;

    // Clamp the payload length and form the IPv4 total length.
    always_comb
    begin
        if (payload_len > 11'(MAX_PAYLOAD))
        begin
            plen_sat = 11'(MAX_PAYLOAD);
        end
        else
        begin
            plen_sat = payload_len;
        end
        ip_len = 16'(IP_TCP_HDR) + 16'(plen_sat);
    end

    // Finish the checksum: add both partial sums, fold the carries twice, invert.
    always_comb
    begin
        full_sum  = 19'(addr_sum_reg) + 19'(misc_sum_reg);
        fold_one  = 17'(full_sum[15:0]) + 17'(full_sum[18:16]);
        fold_two  = fold_one[15:0] + 16'(fold_one[16]);
        push_item = item_reg;
        push_item.hdr_csum = ~fold_two;
    end

    // Holding stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push_valid)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    // Capture the descriptor and the first level of the checksum sum.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.source_ip   <= source_ip;
            item_reg.dest_ip     <= dest_ip;
            item_reg.source_port <= source_port;
            item_reg.dest_port   <= dest_port;
            item_reg.seq_num     <= seq_num;
            item_reg.ack_num     <= ack_num;
            item_reg.tcp_flags   <= tcp_flags;
            item_reg.window_size <= window_size;
            item_reg.payload_len <= plen_sat;
            item_reg.hdr_csum    <= 16'h0000;
            addr_sum_reg <= 18'(source_ip[31:16]) + 18'(source_ip[15:0])
                          + 18'(dest_ip[31:16]) + 18'(dest_ip[15:0]);
            misc_sum_reg <= IP_CONST_SUM + 18'(ip_len) + 18'(seq_num[15:0]);
        end
    end

endmodule

>>> sv/thb_queue.sv
// Small register queue that decouples the front end from the byte sequencer.
module thb_queue #(
    parameter int DEPTH = thb_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  thb_pkg::thb_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output thb_pkg::thb_item_t pop_item
);
    import thb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    thb_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push_valid && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                if (wr_ptr_reg == PTR_W'(DEPTH - 1))
                begin
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (do_pop)
            begin
                if (rd_ptr_reg == PTR_W'(DEPTH - 1))
                begin
                    rd_ptr_reg <= '0;
                end
                else
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/thb_back.sv
// Back end: walks the 54 header bytes of one queued segment, one byte a cycle.
module thb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               queue_empty,
    input  thb_pkg::thb_item_t queue_item,
    output logic               queue_pop,
    input  logic [47:0]        source_mac,
    output logic               byte_valid,
    output logic [7:0]         frame_byte,
    output logic               last_byte,
    output logic [10:0]        frame_length
);
    import thb_pkg::*;

    localparam logic [5:0] LAST_IDX = 6'(HDR_BYTES - 1);

    logic        active_reg;
    logic        active_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    thb_item_t   cur_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic [10:0] out_len_reg;

    logic        at_end;
    logic [7:0]  byte_sel;
    logic [15:0] ip_len;

    assign at_end    = active_reg && (cnt_reg == LAST_IDX);
    assign queue_pop = !queue_empty && (!active_reg || at_end);
    assign ip_len    = 16'(IP_TCP_HDR) + 16'(cur_reg.payload_len);

    // Sequencer: next segment starts right after the last byte of this one.
    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (queue_pop)
        begin
            active_next = 1'b1;
            cnt_next    = 6'd0;
        end
        else if (at_end)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // Byte decoder over the header layout.
    always_comb
    begin
        unique case (cnt_reg) inside
            [6'd0:6'd5]:   byte_sel = BCAST_BYTE;
            6'd6:          byte_sel = source_mac[47:40];
            6'd7:          byte_sel = source_mac[39:32];
            6'd8:          byte_sel = source_mac[31:24];
            6'd9:          byte_sel = source_mac[23:16];
            6'd10:         byte_sel = source_mac[15:8];
            6'd11:         byte_sel = source_mac[7:0];
            6'd12:         byte_sel = ETHERTYPE_IPV4[15:8];
            6'd13:         byte_sel = ETHERTYPE_IPV4[7:0];
            6'd14:         byte_sel = IP_VER_IHL;
            6'd15:         byte_sel = IP_TOS;
            6'd16:         byte_sel = ip_len[15:8];
            6'd17:         byte_sel = ip_len[7:0];
            6'd18:         byte_sel = cur_reg.seq_num[15:8];
            6'd19:         byte_sel = cur_reg.seq_num[7:0];
            6'd20:         byte_sel = IP_FLAGS_DF[15:8];
            6'd21:         byte_sel = IP_FLAGS_DF[7:0];
            6'd22:         byte_sel = IP_TTL;
            6'd23:         byte_sel = IP_PROTOCOL;
            6'd24:         byte_sel = cur_reg.hdr_csum[15:8];
            6'd25:         byte_sel = cur_reg.hdr_csum[7:0];
            6'd26:         byte_sel = cur_reg.source_ip[31:24];
            6'd27:         byte_sel = cur_reg.source_ip[23:16];
            6'd28:         byte_sel = cur_reg.source_ip[15:8];
            6'd29:         byte_sel = cur_reg.source_ip[7:0];
            6'd30:         byte_sel = cur_reg.dest_ip[31:24];
            6'd31:         byte_sel = cur_reg.dest_ip[23:16];
            6'd32:         byte_sel = cur_reg.dest_ip[15:8];
            6'd33:         byte_sel = cur_reg.dest_ip[7:0];
            6'd34:         byte_sel = cur_reg.source_port[15:8];
            6'd35:         byte_sel = cur_reg.source_port[7:0];
            6'd36:         byte_sel = cur_reg.dest_port[15:8];
            6'd37:         byte_sel = cur_reg.dest_port[7:0];
            6'd38:         byte_sel = cur_reg.seq_num[31:24];
            6'd39:         byte_sel = cur_reg.seq_num[23:16];
            6'd40:         byte_sel = cur_reg.seq_num[15:8];
            6'd41:         byte_sel = cur_reg.seq_num[7:0];
            6'd42:         byte_sel = cur_reg.ack_num[31:24];
            6'd43:         byte_sel = cur_reg.ack_num[23:16];
            6'd44:         byte_sel = cur_reg.ack_num[15:8];
            6'd45:         byte_sel = cur_reg.ack_num[7:0];
            6'd46:         byte_sel = TCP_DATA_OFFSET;
            6'd47:         byte_sel = cur_reg.tcp_flags;
            6'd48:         byte_sel = cur_reg.window_size[15:8];
            6'd49:         byte_sel = cur_reg.window_size[7:0];
            default:       byte_sel = 8'h00;
        endcase
    end

    // Control state and the output strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cnt_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= active_reg;
        end
    end

    // Current segment and the registered output byte.
    always_ff @(posedge clk)
    begin
        if (queue_pop)
        begin
            cur_reg <= queue_item;
        end
        out_byte_reg <= byte_sel;
        out_last_reg <= (cnt_reg == LAST_IDX);
        out_len_reg  <= 11'(HDR_BYTES) + cur_reg.payload_len;
    end

    assign byte_valid   = out_valid_reg;
    assign frame_byte   = out_byte_reg;
    assign last_byte    = out_last_reg;
    assign frame_length = out_len_reg;

endmodule

>>> sv/tcp_ipv4_frame_header_builder.sv
// Top level of the TCP/IPv4 Ethernet frame header builder.
//
// A segment descriptor is transferred at a clock edge where start is high and
// busy is low. The block answers with the 54-byte Ethernet II + IPv4 + TCP
// header, one byte per cycle on frame_byte, each marked by byte_valid for
// exactly one cycle; last_byte flags the 54th byte and frame_length (54 plus
// the clamped payload length) rides along with every byte.
// The source MAC is written through cfg_valid/cfg_data; cfg_ready is always
// high. Write it only while no header is in flight.
// On its way out a descriptor passes the front holding stage, the queue, the
// sequencer's segment register and the output byte register.
// The byte sequencer emits one header byte per cycle. The front end computes
// the IPv4 checksum and a small queue holds finished descriptors, so a new
// descriptor is taken while the previous header is still going out; busy
// rises only when the queue and the front holding stage are both full.
// The receiver cannot stall: every byte is taken in its cycle.
// Reset clears the queue and sequencer and sets the source MAC to its
// default value; no byte is in flight afterwards.
module tcp_ipv4_frame_header_builder #(
    parameter int QUEUE_DEPTH = thb_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] source_ip,
    input  logic [31:0] dest_ip,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [31:0] seq_num,
    input  logic [31:0] ack_num,
    input  logic [7:0]  tcp_flags,
    input  logic [15:0] window_size,
    input  logic [10:0] payload_len,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [47:0] cfg_data,
    output logic        byte_valid,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    output logic [10:0] frame_length
);
    import thb_pkg::*;

    logic        mac_write;
    logic [47:0] mac_reg;
    thb_item_t   push_item;
    thb_item_t   pop_item;
    logic        push_valid;
    logic        queue_full;
    logic        queue_empty;
    logic        queue_pop;

    assign cfg_ready = 1'b1;
    assign mac_write = cfg_valid && cfg_ready;

    // Source MAC configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_reg <= MAC_RESET;
        end
        else if (mac_write)
        begin
            mac_reg <= cfg_data;
        end
    end

    // Descriptor intake and checksum.
    thb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .source_ip   (source_ip),
        .dest_ip     (dest_ip),
        .source_port (source_port),
        .dest_port   (dest_port),
        .seq_num     (seq_num),
        .ack_num     (ack_num),
        .tcp_flags   (tcp_flags),
        .window_size (window_size),
        .payload_len (payload_len),
        .push_valid  (push_valid),
        .push_item   (push_item),
        .queue_full  (queue_full)
    );

    // Queue between front end and sequencer.
    thb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (queue_pop),
        .empty      (queue_empty),
        .pop_item   (pop_item)
    );

    // Header byte sequencer.
    thb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .queue_item   (pop_item),
        .queue_pop    (queue_pop),
        .source_mac   (mac_reg),
        .byte_valid   (byte_valid),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte),
        .frame_length (frame_length)
    );

endmodule
